// File: src/sfo_pkg.sv
package sfo_pkg;

    localparam int BUF_BYTES_DEF = 1024;
    localparam int TITLE_MAX_DEF = 128;
    localparam int ID_MAX_DEF    = 16;

    localparam logic [31:0] MAGIC_WORD  = 32'h4653_5000;
    localparam int          HDR_BYTES   = 20;
    localparam int          ENTRY_BYTES = 16;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_SHORT  = 3'd1;
    localparam logic [2:0] ST_MAGIC  = 3'd2;
    localparam logic [2:0] ST_OFFSET = 3'd3;
    localparam logic [2:0] ST_LARGE  = 3'd4;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // key names, byte i at [8*i +: 8], zero padded
    localparam int KEY_TITLE = 0;
    localparam int KEY_DISC  = 1;
    localparam int KEY_TID   = 2;
    localparam int KEY_CAT   = 3;
    localparam logic [3:0][71:0] KEY_NAMES = '{
        72'h00_59_52_4F_47_45_54_41_43,   // category
        72'h00_44_49_5F_45_4C_54_49_54,   // title id
        72'h00_00_44_49_5F_43_53_49_44,   // disc id
        72'h00_00_00_00_45_4C_54_49_54    // title
    };
    localparam logic [3:0][3:0] KEY_LENS = '{4'd8, 4'd8, 4'd7, 4'd5};

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
        logic       last;
        logic [9:0] read_addr;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] category;
        logic [32:0] title_start;
        logic [6:0]  title_len;
        logic [32:0] disc_start;
        logic [3:0]  disc_len;
        logic [32:0] tid_start;
        logic [3:0]  tid_len;
        logic [7:0]  read_data;
    } rsp_t;

endpackage

// File: src/sfo_metadata_extractor.sv
// Metadata file extractor. Load commands append one file byte per transfer to an internal
// buffer of BUF_BYTES bytes; a load marked last starts a parse of the header and the
// 16-byte entry table and gives one result with a status, the held title, disc id and
// title id locations and the held category code. A read command returns one buffered
// byte (zero beyond the loaded size) with the held values. A load not marked last leaves
// the input free for the next transfer. Reads and parses fetch bytes one at a time through
// the single registered read port of the byte buffer, each byte taking an issue and a
// capture step. No further transfer is taken until a result has been moved into the
// output register.
module sfo_metadata_extractor
    import sfo_pkg::*;
#(
    parameter int BUF_BYTES = BUF_BYTES_DEF,
    parameter int TITLE_MAX = TITLE_MAX_DEF,
    parameter int ID_MAX    = ID_MAX_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int AW = $clog2(BUF_BYTES);
    localparam int LW = $clog2(BUF_BYTES + 1);
    localparam logic [31:0] TITLE_CLAMP = 32'(TITLE_MAX - 1);
    localparam logic [31:0] ID_CLAMP    = 32'(ID_MAX - 1);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ISSUE = 4'd1;
    localparam logic [3:0] S_CAPT  = 4'd2;
    localparam logic [3:0] S_START = 4'd3;
    localparam logic [3:0] S_MAGIC = 4'd4;
    localparam logic [3:0] S_KB    = 4'd5;
    localparam logic [3:0] S_VB    = 4'd6;
    localparam logic [3:0] S_CNT   = 4'd7;
    localparam logic [3:0] S_KOFF  = 4'd8;
    localparam logic [3:0] S_VLEN  = 4'd9;
    localparam logic [3:0] S_VOFF  = 4'd10;
    localparam logic [3:0] S_KEY   = 4'd11;
    localparam logic [3:0] S_APPLY = 4'd12;
    localparam logic [3:0] S_CAT   = 4'd13;
    localparam logic [3:0] S_RDONE = 4'd14;
    localparam logic [3:0] S_DONE  = 4'd15;

    // byte buffer, one write port and one registered read port
    logic [7:0] mem [BUF_BYTES];
    logic [7:0] mem_q;
    logic       mem_we;
    logic [AW-1:0] mem_wa;

    logic [3:0]  state_reg, state_next;
    logic [3:0]  ret_reg, ret_next;
    logic [33:0] fa_reg, fa_next;          // byte fetch address
    logic [2:0]  nleft_reg, nleft_next;    // bytes left in this fetch
    logic [31:0] acc_reg, acc_next;        // little-endian assembly, newest byte on top
    logic        ok_reg;                   // fetched address lies inside the loaded bytes

    logic [LW-1:0] loaded_count_reg, loaded_count_next;
    logic          overflow_reg, overflow_next;
    logic          closed_reg, closed_next;

    logic [15:0] held_cat_reg, held_cat_next;
    logic [32:0] title_start_reg, title_start_next;
    logic [32:0] disc_start_reg, disc_start_next;
    logic [32:0] tid_start_reg, tid_start_next;
    logic [6:0]  title_len_reg, title_len_next;
    logic [3:0]  disc_len_reg, disc_len_next;
    logic [3:0]  tid_len_reg, tid_len_next;

    logic [31:0] kb_reg, kb_next;
    logic [31:0] vb_reg, vb_next;
    logic [LW-1:0] ent_left_reg, ent_left_next;
    logic [33:0] ent_reg, ent_next;
    logic [31:0] vlen_reg, vlen_next;
    logic [32:0] val_reg, val_next;
    logic [3:0]  kidx_reg, kidx_next;
    logic [3:0]  match_reg, match_next;

    logic [2:0]  status_reg, status_next;
    logic [7:0]  rdata_reg, rdata_next;
    logic        rsp_valid_reg, rsp_valid_next;
    rsp_t        rsp_reg, rsp_next;

    logic [33:0]   size34;
    logic [LW-1:0] base_count;
    logic [LW-1:0] fit;
    logic [7:0]    fetched;
    logic [31:0]   tclamp, iclamp;

    assign size34  = {{(34 - LW){1'b0}}, loaded_count_reg};
    assign fetched = ok_reg ? mem_q : 8'd0;
    assign fit     = (loaded_count_reg - LW'(HDR_BYTES)) >> 4;
    assign tclamp  = (vlen_reg > TITLE_CLAMP) ? TITLE_CLAMP : vlen_reg;
    assign iclamp  = (vlen_reg > ID_CLAMP) ? ID_CLAMP : vlen_reg;
    assign base_count = closed_reg ? '0 : loaded_count_reg;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= req.data_byte;
        end
        mem_q <= mem[fa_reg[AW-1:0]];
    end

    always_comb
    begin
        state_next        = state_reg;
        ret_next          = ret_reg;
        fa_next           = fa_reg;
        nleft_next        = nleft_reg;
        acc_next          = acc_reg;
        loaded_count_next = loaded_count_reg;
        overflow_next     = overflow_reg;
        closed_next       = closed_reg;
        held_cat_next     = held_cat_reg;
        title_start_next  = title_start_reg;
        disc_start_next   = disc_start_reg;
        tid_start_next    = tid_start_reg;
        title_len_next    = title_len_reg;
        disc_len_next     = disc_len_reg;
        tid_len_next      = tid_len_reg;
        kb_next           = kb_reg;
        vb_next           = vb_reg;
        ent_left_next     = ent_left_reg;
        ent_next          = ent_reg;
        vlen_next         = vlen_reg;
        val_next          = val_reg;
        kidx_next         = kidx_reg;
        match_next        = match_reg;
        status_next       = status_reg;
        rdata_next        = rdata_reg;
        rsp_valid_next    = rsp_valid_reg && rsp_stall;
        rsp_next          = rsp_reg;
        mem_we            = 1'b0;
        mem_wa            = base_count[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.cmd == CMD_READ)
                    begin
                        fa_next    = {24'd0, req.read_addr};
                        nleft_next = 3'd1;
                        ret_next   = S_RDONE;
                        state_next = S_ISSUE;
                    end
                    else
                    begin
                        // a load after a parse opens a new file
                        overflow_next = closed_reg ? 1'b0 : overflow_reg;
                        closed_next   = 1'b0;
                        if (base_count < LW'(BUF_BYTES))
                        begin
                            mem_we            = 1'b1;
                            loaded_count_next = base_count + 1'b1;
                        end
                        else
                        begin
                            loaded_count_next = base_count;
                            overflow_next     = 1'b1;
                        end
                        if (req.last)
                        begin
                            state_next = S_START;
                        end
                    end
                end
            end

            S_ISSUE:
            begin
                state_next = S_CAPT;
            end

            S_CAPT:
            begin
                acc_next = {fetched, acc_reg[31:8]};
                fa_next  = fa_reg + 34'd1;
                if (nleft_reg == 3'd1)
                begin
                    state_next = ret_reg;
                end
                else
                begin
                    nleft_next = nleft_reg - 3'd1;
                    state_next = S_ISSUE;
                end
            end

            S_START:
            begin
                closed_next = 1'b1;
                rdata_next  = 8'd0;
                if (overflow_reg)
                begin
                    status_next = ST_LARGE;
                    state_next  = S_DONE;
                end
                else if (loaded_count_reg < LW'(HDR_BYTES))
                begin
                    status_next = ST_SHORT;
                    state_next  = S_DONE;
                end
                else
                begin
                    held_cat_next    = '0;
                    title_start_next = '0;
                    disc_start_next  = '0;
                    tid_start_next   = '0;
                    title_len_next   = '0;
                    disc_len_next    = '0;
                    tid_len_next     = '0;
                    fa_next          = 34'd0;
                    nleft_next       = 3'd4;
                    ret_next         = S_MAGIC;
                    state_next       = S_ISSUE;
                end
            end

            S_MAGIC:
            begin
                if (acc_reg != MAGIC_WORD)
                begin
                    status_next = ST_MAGIC;
                    state_next  = S_DONE;
                end
                else
                begin
                    fa_next    = 34'd8;
                    nleft_next = 3'd4;
                    ret_next   = S_KB;
                    state_next = S_ISSUE;
                end
            end

            S_KB:
            begin
                kb_next    = acc_reg;
                fa_next    = 34'd12;
                nleft_next = 3'd4;
                ret_next   = S_VB;
                state_next = S_ISSUE;
            end

            S_VB:
            begin
                vb_next = acc_reg;
                if (({2'b00, kb_reg} >= size34) || ({2'b00, acc_reg} >= size34))
                begin
                    status_next = ST_OFFSET;
                    state_next  = S_DONE;
                end
                else
                begin
                    fa_next    = 34'd16;
                    nleft_next = 3'd4;
                    ret_next   = S_CNT;
                    state_next = S_ISSUE;
                end
            end

            S_CNT:
            begin
                // entry count clamped to whole entries inside the loaded bytes
                if (acc_reg > 32'(fit))
                begin
                    ent_left_next = fit;
                end
                else
                begin
                    ent_left_next = acc_reg[LW-1:0];
                end
                ent_next = 34'(HDR_BYTES);
                if ((acc_reg == 32'd0) || (fit == '0))
                begin
                    status_next = ST_OK;
                    state_next  = S_DONE;
                end
                else
                begin
                    fa_next    = 34'(HDR_BYTES);
                    nleft_next = 3'd2;
                    ret_next   = S_KOFF;
                    state_next = S_ISSUE;
                end
            end

            S_KOFF:
            begin
                // key address parked in val_reg until the key walk starts
                val_next   = {1'b0, kb_reg} + {17'd0, acc_reg[31:16]};
                fa_next    = ent_reg + 34'd4;
                nleft_next = 3'd4;
                ret_next   = S_VLEN;
                state_next = S_ISSUE;
            end

            S_VLEN:
            begin
                vlen_next  = acc_reg;
                fa_next    = ent_reg + 34'd12;
                nleft_next = 3'd4;
                ret_next   = S_VOFF;
                state_next = S_ISSUE;
            end

            S_VOFF:
            begin
                fa_next    = {1'b0, val_reg};
                val_next   = {1'b0, vb_reg} + {1'b0, acc_reg};
                kidx_next  = 4'd0;
                match_next = 4'b1111;
                nleft_next = 3'd1;
                ret_next   = S_KEY;
                state_next = S_ISSUE;
            end

            S_KEY:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    if ((kidx_reg <= KEY_LENS[k]) &&
                        (acc_reg[31:24] != KEY_NAMES[k][8*kidx_reg +: 8]))
                    begin
                        match_next[k] = 1'b0;
                    end
                end
                if (kidx_reg == 4'd8)
                begin
                    state_next = S_APPLY;
                end
                else
                begin
                    kidx_next  = kidx_reg + 4'd1;
                    nleft_next = 3'd1;
                    ret_next   = S_KEY;
                    state_next = S_ISSUE;
                end
            end

            S_APPLY:
            begin
                state_next = S_CAT;
                if (match_reg[KEY_TITLE])
                begin
                    title_start_next = val_reg;
                    title_len_next   = tclamp[6:0];
                end
                else if (match_reg[KEY_DISC])
                begin
                    disc_start_next = val_reg;
                    disc_len_next   = iclamp[3:0];
                end
                else if (match_reg[KEY_TID])
                begin
                    tid_start_next = val_reg;
                    tid_len_next   = iclamp[3:0];
                end
                else if (match_reg[KEY_CAT] && (vlen_reg >= 32'd2))
                begin
                    fa_next    = {1'b0, val_reg};
                    nleft_next = 3'd2;
                    ret_next   = S_CAT;
                    state_next = S_ISSUE;
                    match_next = 4'b1000;
                end
                if (state_next == S_CAT)
                begin
                    match_next = 4'b0000;
                end
            end

            S_CAT:
            begin
                // big-endian code; also steps to the next entry
                if (match_reg[KEY_CAT])
                begin
                    held_cat_next = {acc_reg[23:16], acc_reg[31:24]};
                end
                ent_next      = ent_reg + 34'(ENTRY_BYTES);
                ent_left_next = ent_left_reg - 1'b1;
                if (ent_left_reg == LW'(1))
                begin
                    status_next = ST_OK;
                    state_next  = S_DONE;
                end
                else
                begin
                    fa_next    = ent_reg + 34'(ENTRY_BYTES);
                    nleft_next = 3'd2;
                    ret_next   = S_KOFF;
                    state_next = S_ISSUE;
                end
            end

            S_RDONE:
            begin
                rdata_next  = acc_reg[31:24];
                status_next = ST_OK;
                state_next  = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = status_reg;
                    rsp_next.category    = held_cat_reg;
                    rsp_next.title_start = title_start_reg;
                    rsp_next.title_len   = title_len_reg;
                    rsp_next.disc_start  = disc_start_reg;
                    rsp_next.disc_len    = disc_len_reg;
                    rsp_next.tid_start   = tid_start_reg;
                    rsp_next.tid_len     = tid_len_reg;
                    rsp_next.read_data   = rdata_reg;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            loaded_count_reg <= '0;
            overflow_reg     <= 1'b0;
            closed_reg       <= 1'b0;
            held_cat_reg     <= '0;
            title_start_reg  <= '0;
            disc_start_reg   <= '0;
            tid_start_reg    <= '0;
            title_len_reg    <= '0;
            disc_len_reg     <= '0;
            tid_len_reg      <= '0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            loaded_count_reg <= loaded_count_next;
            overflow_reg     <= overflow_next;
            closed_reg       <= closed_next;
            held_cat_reg     <= held_cat_next;
            title_start_reg  <= title_start_next;
            disc_start_reg   <= disc_start_next;
            tid_start_reg    <= tid_start_next;
            title_len_reg    <= title_len_next;
            disc_len_reg     <= disc_len_next;
            tid_len_reg      <= tid_len_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        ret_reg      <= ret_next;
        fa_reg       <= fa_next;
        nleft_reg    <= nleft_next;
        acc_reg      <= acc_next;
        ok_reg       <= (fa_reg < size34);
        kb_reg       <= kb_next;
        vb_reg       <= vb_next;
        ent_left_reg <= ent_left_next;
        ent_reg      <= ent_next;
        vlen_reg     <= vlen_next;
        val_reg      <= val_next;
        kidx_reg     <= kidx_next;
        match_reg    <= match_next;
        status_reg   <= status_next;
        rdata_reg    <= rdata_next;
        rsp_reg      <= rsp_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        loaded_count_reg <= LW'(BUF_BYTES))
        else $error("loaded count beyond buffer");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |-> (loaded_count_reg == LW'(BUF_BYTES)))
        else $error("overflow without full buffer");

    a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.read_data != 8'd0)) |-> (rsp.status == ST_OK))
        else $error("read data with bad status");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) && $past(state_reg == S_DONE) && !rsp_valid_reg
        |=> (state_reg == S_IDLE))
        else $error("result not moved to output");
`endif

endmodule
